### hdl/tlik_pkg.sv
// ----------------------------------------------------------------------------
// tlik_pkg
// shared types and constants for the two-link inverse kinematics core
// ----------------------------------------------------------------------------
package tlik_pkg;

    // cordic angle table, 32 fraction bits
    localparam logic [31:0] ATAN_Q32 [32] = '{
        32'd3373259426, 32'd1991351317, 32'd1052175346, 32'd534100634,
        32'd268086747, 32'd134174062, 32'd67103403, 32'd33553749,
        32'd16777130, 32'd8388597, 32'd4194302, 32'd2097151,
        32'd1048575, 32'd524287, 32'd262143, 32'd131071,
        32'd65535, 32'd32767, 32'd16383, 32'd8191, 32'd4095, 32'd2047,
        32'd1023, 32'd511, 32'd255, 32'd127, 32'd63, 32'd31,
        32'd15, 32'd7, 32'd3, 32'd1
    };

    localparam logic signed [35:0] PI_Q32      = 36'sd13493037705;
    localparam logic signed [35:0] HALF_PI_Q32 = 36'sd6746518852;

    // register indexes
    localparam logic [2:0] REG_SHOULDER_HEIGHT = 3'd0;
    localparam logic [2:0] REG_UPPER_ARM       = 3'd1;
    localparam logic [2:0] REG_FOREARM         = 3'd2;
    localparam logic [2:0] REG_WRIST_OFFSET    = 3'd3;
    localparam logic [2:0] REG_MIN_REACH       = 3'd4;
    localparam logic [2:0] REG_REACH_MARGIN    = 3'd5;

    // pipeline control per stage, not used by the modules
    typedef struct packed {
        logic valid;
    } tlik_ctl_t;

endpackage

### hdl/tlik_isqrt.sv
// ----------------------------------------------------------------------------
// tlik_isqrt
// pipelined floor square root, two result bits per stage
// ----------------------------------------------------------------------------
module tlik_isqrt
    import tlik_pkg::*;
#(
    parameter int IN_W = 64,
    parameter int TAG_W = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  logic [IN_W-1:0]      in_val,
    input  logic [TAG_W-1:0]     in_tag,
    output logic                 out_valid,
    output logic [IN_W/2-1:0]    out_root,
    output logic [TAG_W-1:0]     out_tag
);
    localparam int RW = IN_W / 2;
    localparam int NS = (RW + 1) / 2;

    logic [NS:0]            vld_reg;
    logic [IN_W-1:0]        rem_reg  [NS+1];
    logic [RW-1:0]          root_reg [NS+1];
    logic [IN_W-1:0]        src_reg  [NS+1];
    logic [TAG_W-1:0]       tag_reg  [NS+1];

    // stage entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (adv)
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            src_reg[0]  <= in_val;
            tag_reg[0]  <= in_tag;
        end
    end

    // two restoring digit steps per stage
    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        logic [IN_W-1:0] rem_next;
        logic [RW-1:0]   root_next;
        logic [IN_W-1:0] src_next;

        always_comb
        begin
            logic [IN_W+1:0] trial;
            logic [IN_W+1:0] remx;
            trial     = '0;
            remx      = '0;
            rem_next  = rem_reg[s];
            root_next = root_reg[s];
            src_next  = src_reg[s];
            for (int k = 0; k < 2; k++)
            begin
                if (2 * s + k < RW)
                begin
                    remx  = {rem_next, src_next[IN_W-1 -: 2]};
                    trial = {root_next, 2'b01};
                    src_next = {src_next[IN_W-3:0], 2'b00};
                    if (remx >= trial)
                    begin
                        rem_next  = IN_W'(remx - trial);
                        root_next = {root_next[RW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next  = IN_W'(remx);
                        root_next = {root_next[RW-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s+1] <= 1'b0;
            else if (adv)
                vld_reg[s+1] <= vld_reg[s];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[s+1]  <= rem_next;
                root_reg[s+1] <= root_next;
                src_reg[s+1]  <= src_next;
                tag_reg[s+1]  <= tag_reg[s];
            end
        end
    end

    assign out_valid = vld_reg[NS];
    assign out_root  = root_reg[NS];
    assign out_tag   = tag_reg[NS];
endmodule

### hdl/tlik_cordic.sv
// ----------------------------------------------------------------------------
// tlik_cordic
// pipelined cordic vectoring atan2 with normalized inputs, one rotation a stage
// ----------------------------------------------------------------------------
module tlik_cordic
    import tlik_pkg::*;
#(
    parameter int IN_W = 62,
    parameter int STAGES = 18,
    parameter int TAG_W = 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    in_valid,
    input  logic signed [IN_W-1:0]  in_y,
    input  logic signed [IN_W-1:0]  in_x,
    input  logic [TAG_W-1:0]        in_tag,
    output logic                    out_valid,
    output logic signed [35:0]      out_angle,
    output logic [TAG_W-1:0]        out_tag
);
    localparam int NS = (STAGES > 32) ? 32 : STAGES;
    localparam int LZW = $clog2(IN_W + 1);

    // pre stage: quadrant fold, zero detect
    logic                    p0_vld_reg;
    logic signed [IN_W:0]    p0_x_reg, p0_y_reg;
    logic signed [35:0]      p0_z_reg;
    logic                    p0_zero_reg;
    logic [TAG_W-1:0]        p0_tag_reg;

    logic signed [IN_W:0] fx, fy;
    logic signed [35:0]   fz;
    always_comb
    begin
        fx = '0;
        fy = '0;
        fz = '0;
        if (in_x < 0)
        begin
            if (in_y >= 0)
            begin
                fx = (IN_W+1)'(in_y);
                fy = -(IN_W+1)'(in_x);
                fz = HALF_PI_Q32;
            end
            else
            begin
                fx = -(IN_W+1)'(in_y);
                fy = (IN_W+1)'(in_x);
                fz = -HALF_PI_Q32;
            end
        end
        else
        begin
            fx = (IN_W+1)'(in_x);
            fy = (IN_W+1)'(in_y);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p0_vld_reg <= 1'b0;
        else if (adv)
            p0_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p0_x_reg    <= fx;
            p0_y_reg    <= fy;
            p0_z_reg    <= fz;
            p0_zero_reg <= (in_x == 0) && (in_y == 0);
            p0_tag_reg  <= in_tag;
        end
    end

    // normalize stage: bit length of max magnitude, shift so it lands at bit 29
    logic [IN_W:0]   ax, ay, am;
    logic [LZW:0]    blen;
    always_comb
    begin
        ax = p0_x_reg[IN_W] ? (IN_W+1)'(-p0_x_reg) : p0_x_reg;
        ay = p0_y_reg[IN_W] ? (IN_W+1)'(-p0_y_reg) : p0_y_reg;
        am = (ax > ay) ? ax : ay;
        blen = '0;
        for (int i = 0; i <= IN_W; i++)
        begin
            if (am[i])
                blen = (LZW+1)'(i + 1);
        end
    end

    logic                 p1_vld_reg;
    logic signed [IN_W:0] p1_x_reg, p1_y_reg;
    logic [LZW:0]         p1_len_reg;
    logic signed [35:0]   p1_z_reg;
    logic                 p1_zero_reg;
    logic [TAG_W-1:0]     p1_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_vld_reg <= 1'b0;
        else if (adv)
            p1_vld_reg <= p0_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_x_reg    <= p0_x_reg;
            p1_y_reg    <= p0_y_reg;
            p1_len_reg  <= blen;
            p1_z_reg    <= p0_z_reg;
            p1_zero_reg <= p0_zero_reg;
            p1_tag_reg  <= p0_tag_reg;
        end
    end

    // shift to 30-bit magnitude (31-bit signed plus growth)
    logic signed [33:0] nx, ny;
    always_comb
    begin
        if (p1_len_reg > (LZW+1)'(30))
        begin
            nx = 34'(p1_x_reg >>> (p1_len_reg - (LZW+1)'(30)));
            ny = 34'(p1_y_reg >>> (p1_len_reg - (LZW+1)'(30)));
        end
        else
        begin
            nx = 34'(p1_x_reg) <<< ((LZW+1)'(30) - p1_len_reg);
            ny = 34'(p1_y_reg) <<< ((LZW+1)'(30) - p1_len_reg);
        end
    end

    logic [NS:0]        vld_reg;
    logic signed [33:0] x_reg [NS+1];
    logic signed [33:0] y_reg [NS+1];
    logic signed [35:0] z_reg [NS+1];
    logic               zr_reg [NS+1];
    logic [TAG_W-1:0]   tag_reg [NS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (adv)
            vld_reg[0] <= p1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[0]   <= nx;
            y_reg[0]   <= ny;
            z_reg[0]   <= p1_z_reg;
            zr_reg[0]  <= p1_zero_reg;
            tag_reg[0] <= p1_tag_reg;
        end
    end

    // micro-rotations
    for (genvar i = 0; i < NS; i++)
    begin : g_rot
        logic signed [33:0] dx, dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i+1] <= 1'b0;
            else if (adv)
                vld_reg[i+1] <= vld_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (!y_reg[i][33])
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + 36'(ATAN_Q32[i]);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - 36'(ATAN_Q32[i]);
                end
                zr_reg[i+1]  <= zr_reg[i];
                tag_reg[i+1] <= tag_reg[i];
            end
        end
    end

    assign out_valid = vld_reg[NS];
    assign out_angle = zr_reg[NS] ? '0 : z_reg[NS];
    assign out_tag   = tag_reg[NS];
endmodule

### hdl/two_link_arm_inverse_kinematics_core.sv
// ----------------------------------------------------------------------------
// two_link_arm_inverse_kinematics_core
// throughput: one beat per cycle; the whole pipeline holds while a result beat
// waits under out_stall
// reset: rst_n clears all valid bits and loads the register reset values
// stages: isqrt units step two root bits and cordic units one rotation per stage
// ----------------------------------------------------------------------------
module two_link_arm_inverse_kinematics_core
    import tlik_pkg::*;
#(
    parameter int CORDIC_STAGES = 18
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [19:0] target_x,
    input  logic signed [19:0] target_y,
    input  logic signed [19:0] target_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [18:0] base_angle,
    output logic signed [19:0] shoulder_angle,
    output logic signed [18:0] elbow_angle,
    output logic               reach_clamped
);
    localparam int FB = 16;
    localparam logic signed [19:0] PI_F = 20'sd205887;

    // register file
    logic [17:0] sh_reg, l2_reg, l3_reg, wo_reg;
    logic [15:0] mr_reg, rm_reg;
    logic        wr;
    logic [2:0]  ridx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign ridx   = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sh_reg <= 18'd21824;
            l2_reg <= 18'd20709;
            l3_reg <= 18'd25166;
            wo_reg <= 18'd7012;
            mr_reg <= 16'd6554;
            rm_reg <= 16'd655;
        end
        else if (wr)
        begin
            unique case (ridx)
                REG_SHOULDER_HEIGHT: sh_reg <= pwdata[17:0];
                REG_UPPER_ARM:       l2_reg <= pwdata[17:0];
                REG_FOREARM:         l3_reg <= pwdata[17:0];
                REG_WRIST_OFFSET:    wo_reg <= pwdata[17:0];
                REG_MIN_REACH:       mr_reg <= pwdata[15:0];
                REG_REACH_MARGIN:    rm_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (ridx)
            REG_SHOULDER_HEIGHT: prdata = 32'(sh_reg);
            REG_UPPER_ARM:       prdata = 32'(l2_reg);
            REG_FOREARM:         prdata = 32'(l3_reg);
            REG_WRIST_OFFSET:    prdata = 32'(wo_reg);
            REG_MIN_REACH:       prdata = 32'(mr_reg);
            REG_REACH_MARGIN:    prdata = 32'(rm_reg);
            default:             prdata = '0;
        endcase
    end

    // global advance; output register holds while stalled
    logic adv;
    logic ov_reg;
    assign adv       = !(ov_reg && out_stall);
    assign in_stall  = !adv;
    assign out_valid = ov_reg;

    // ---------------- stage a: squares of x and y
    // tag layouts are kept wide; unused bits synthesize away
    localparam int TW = 160;
    logic        a_vld_reg;
    logic [39:0] a_sx_reg, a_sy_reg;
    logic signed [19:0] a_x_reg, a_y_reg, a_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else if (adv)
            a_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_sx_reg <= 40'(target_x * target_x);
            a_sy_reg <= 40'(target_y * target_y);
            a_x_reg  <= target_x;
            a_y_reg  <= target_y;
            a_z_reg  <= target_z;
        end
    end

    // ---------------- r = isqrt(x^2 + y^2)
    logic [41:0]  r_sum;
    logic         r_vld;
    logic [20:0]  r_root;
    logic [TW-1:0] r_tag_in, r_tag;
    assign r_sum    = 42'(a_sx_reg) + 42'(a_sy_reg);
    assign r_tag_in = TW'({a_x_reg, a_y_reg, a_z_reg});

    tlik_isqrt #(.IN_W(42), .TAG_W(TW)) u_r_sqrt (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_valid(a_vld_reg), .in_val(r_sum), .in_tag(r_tag_in),
        .out_valid(r_vld), .out_root(r_root), .out_tag(r_tag)
    );

    // ---------------- stage b: h and squares
    logic               b_vld_reg;
    logic [41:0]        b_rr_reg, b_hh_reg;
    logic signed [20:0] b_h_reg;
    logic [20:0]        b_r_reg;
    logic signed [19:0] b_x_reg, b_y_reg;
    logic signed [20:0] h_c;
    assign h_c = 21'(signed'(r_tag[19:0])) - 21'(sh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_vld_reg <= 1'b0;
        else if (adv)
            b_vld_reg <= r_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_rr_reg <= 42'(r_root * r_root);
            b_hh_reg <= 42'(h_c * h_c);
            b_h_reg  <= h_c;
            b_r_reg  <= r_root;
            b_x_reg  <= r_tag[59:40];
            b_y_reg  <= r_tag[39:20];
        end
    end

    // ---------------- reach = isqrt(r^2 + h^2)
    logic [43:0]   d_sum;
    logic          d_vld;
    logic [21:0]   d_root;
    logic [TW-1:0] d_tag_in, d_tag;
    assign d_sum    = 44'(b_rr_reg) + 44'(b_hh_reg);
    assign d_tag_in = TW'({b_x_reg, b_y_reg, b_h_reg, b_r_reg});

    tlik_isqrt #(.IN_W(44), .TAG_W(TW)) u_d_sqrt (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_valid(b_vld_reg), .in_val(d_sum), .in_tag(d_tag_in),
        .out_valid(d_vld), .out_root(d_root), .out_tag(d_tag)
    );

    // ---------------- stage c: clamp
    logic signed [23:0] reach_c, upper_c, dcl_c;
    logic               clamp_c;
    always_comb
    begin
        reach_c = 24'(d_root) - 24'(wo_reg);
        upper_c = 24'(l2_reg) + 24'(l3_reg) - 24'(rm_reg);
        dcl_c   = reach_c;
        clamp_c = 1'b0;
        if (reach_c < signed'(24'(mr_reg)))
        begin
            dcl_c   = 24'(mr_reg);
            clamp_c = 1'b1;
        end
        else if (reach_c > upper_c)
        begin
            dcl_c   = upper_c;
            clamp_c = 1'b1;
        end
    end

    logic               c_vld_reg;
    logic signed [23:0] c_d_reg;
    logic               c_cl_reg;
    logic [TW-1:0]      c_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_vld_reg <= 1'b0;
        else if (adv)
            c_vld_reg <= d_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_d_reg   <= dcl_c;
            c_cl_reg  <= clamp_c;
            c_tag_reg <= d_tag;
        end
    end

    // ---------------- stage e: products
    logic               e_vld_reg;
    logic signed [47:0] e_dd_reg;
    logic [35:0]        e_l22_reg, e_l33_reg, e_l23_reg;
    logic               e_cl_reg;
    logic [TW-1:0]      e_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_vld_reg <= 1'b0;
        else if (adv)
            e_vld_reg <= c_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_dd_reg  <= 48'(c_d_reg * c_d_reg);
            e_l22_reg <= 36'(l2_reg * l2_reg);
            e_l33_reg <= 36'(l3_reg * l3_reg);
            e_l23_reg <= 36'(l2_reg * l3_reg);
            e_cl_reg  <= c_cl_reg;
            e_tag_reg <= c_tag_reg;
        end
    end

    // ---------------- stage f: numerator, denominator, saturation
    logic signed [49:0] num_c;
    logic [37:0]        den_c;
    logic [1:0]         csel_c;
    always_comb
    begin
        num_c = 50'(e_dd_reg) - 50'(e_l22_reg) - 50'(e_l33_reg);
        den_c = {1'b0, e_l23_reg, 1'b0};
        if (den_c == '0)
            csel_c = num_c >= 0 ? 2'd1 : 2'd2;
        else if (num_c >= signed'(50'(den_c)))
            csel_c = 2'd1;
        else if (num_c <= -signed'(50'(den_c)))
            csel_c = 2'd2;
        else
            csel_c = 2'd0;
    end

    logic               f_vld_reg;
    logic [37:0]        f_mag_reg, f_den_reg;
    logic               f_neg_reg;
    logic [1:0]         f_sel_reg;
    logic               f_cl_reg;
    logic [TW-1:0]      f_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_vld_reg <= 1'b0;
        else if (adv)
            f_vld_reg <= e_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_mag_reg <= 38'(num_c[49] ? -num_c : num_c);
            f_den_reg <= den_c;
            f_neg_reg <= num_c[49];
            f_sel_reg <= csel_c;
            f_cl_reg  <= e_cl_reg;
            f_tag_reg <= e_tag_reg;
        end
    end

    // ---------------- divide: mag*2^16 / den, one quotient bit per stage
    localparam int QB = FB;
    logic [QB:0]   q_vld_reg;
    logic [38:0]   q_rem_reg [QB+1];
    logic [37:0]   q_den_reg [QB+1];
    logic [QB-1:0] q_quo_reg [QB+1];
    logic          q_neg_reg [QB+1];
    logic [1:0]    q_sel_reg [QB+1];
    logic          q_cl_reg  [QB+1];
    logic [TW-1:0] q_tag_reg [QB+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_vld_reg[0] <= 1'b0;
        else if (adv)
            q_vld_reg[0] <= f_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_rem_reg[0] <= 39'(f_sel_reg == 2'd0 ? f_mag_reg : 38'd0);
            q_den_reg[0] <= f_den_reg;
            q_quo_reg[0] <= '0;
            q_neg_reg[0] <= f_neg_reg;
            q_sel_reg[0] <= f_sel_reg;
            q_cl_reg[0]  <= f_cl_reg;
            q_tag_reg[0] <= f_tag_reg;
        end
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_div
        logic [39:0] sh;
        assign sh = {q_rem_reg[k], 1'b0};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                q_vld_reg[k+1] <= 1'b0;
            else if (adv)
                q_vld_reg[k+1] <= q_vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (sh >= 40'(q_den_reg[k]))
                begin
                    q_rem_reg[k+1] <= 39'(sh - 40'(q_den_reg[k]));
                    q_quo_reg[k+1] <= {q_quo_reg[k][QB-2:0], 1'b1};
                end
                else
                begin
                    q_rem_reg[k+1] <= 39'(sh);
                    q_quo_reg[k+1] <= {q_quo_reg[k][QB-2:0], 1'b0};
                end
                q_den_reg[k+1] <= q_den_reg[k];
                q_neg_reg[k+1] <= q_neg_reg[k];
                q_sel_reg[k+1] <= q_sel_reg[k];
                q_cl_reg[k+1]  <= q_cl_reg[k];
                q_tag_reg[k+1] <= q_tag_reg[k];
            end
        end
    end

    // ---------------- stage g: cosine value and c^2
    logic signed [17:0] cos_c;
    always_comb
    begin
        unique case (q_sel_reg[QB])
            2'd1:    cos_c = 18'sd65536;
            2'd2:    cos_c = -18'sd65536;
            default: cos_c = q_neg_reg[QB] ? -18'(q_quo_reg[QB])
                                           : 18'(q_quo_reg[QB]);
        endcase
    end

    logic               g_vld_reg;
    logic signed [17:0] g_c_reg;
    logic [33:0]        g_cc_reg;
    logic               g_cl_reg;
    logic [TW-1:0]      g_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g_vld_reg <= 1'b0;
        else if (adv)
            g_vld_reg <= q_vld_reg[QB];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g_c_reg   <= cos_c;
            g_cc_reg  <= 34'(cos_c * cos_c);
            g_cl_reg  <= q_cl_reg[QB];
            g_tag_reg <= q_tag_reg[QB];
        end
    end

    // ---------------- s = isqrt(2^32 - c^2)
    logic [33:0]   s_in;
    logic          s_vld;
    logic [16:0]   s_root;
    logic [TW-1:0] s_tag_in, s_tag;
    assign s_in     = 34'h1_0000_0000 - g_cc_reg;
    assign s_tag_in = TW'({g_cl_reg, g_c_reg, g_tag_reg[101:0]});

    tlik_isqrt #(.IN_W(34), .TAG_W(TW)) u_s_sqrt (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_valid(g_vld_reg), .in_val(s_in), .in_tag(s_tag_in),
        .out_valid(s_vld), .out_root(s_root), .out_tag(s_tag)
    );

    // tag fields after the sine root
    logic               t_cl;
    logic signed [17:0] t_c;
    logic signed [19:0] t_x, t_y;
    logic signed [20:0] t_h;
    logic [20:0]        t_r;
    assign t_cl = s_tag[120];
    assign t_c  = s_tag[119:102];
    assign t_x  = s_tag[81:62];
    assign t_y  = s_tag[61:42];
    assign t_h  = s_tag[41:21];
    assign t_r  = s_tag[20:0];

    // ---------------- stage h: beta operands
    logic               h_vld_reg;
    logic signed [36:0] h_by_reg;
    logic signed [37:0] h_bx_reg;
    logic [16:0]        h_s_reg;
    logic signed [17:0] h_c_reg;
    logic signed [19:0] h_x_reg, h_y_reg;
    logic signed [20:0] h_h_reg;
    logic [20:0]        h_r_reg;
    logic               h_cl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            h_vld_reg <= 1'b0;
        else if (adv)
            h_vld_reg <= s_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h_by_reg <= 37'(signed'({1'b0, l3_reg}) * signed'({1'b0, s_root}));
            h_bx_reg <= 38'({2'b00, l2_reg, 16'd0})
                      - 38'(signed'({1'b0, l3_reg}) * t_c);
            h_s_reg  <= s_root;
            h_c_reg  <= t_c;
            h_x_reg  <= t_x;
            h_y_reg  <= t_y;
            h_h_reg  <= t_h;
            h_r_reg  <= t_r;
            h_cl_reg <= t_cl;
        end
    end

    // four parallel cordic units
    localparam int CW = 38;
    logic               cb_v, ce_v, ca_v, cbt_v;
    logic signed [35:0] ang_base, ang_elb, ang_alp, ang_bet;
    logic [TW-1:0]      cb_tag;

    tlik_cordic #(.IN_W(CW), .STAGES(CORDIC_STAGES), .TAG_W(TW)) u_base (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(h_vld_reg),
        .in_y(CW'(h_y_reg)), .in_x(CW'(h_x_reg)), .in_tag(TW'(h_cl_reg)),
        .out_valid(cb_v), .out_angle(ang_base), .out_tag(cb_tag)
    );
    tlik_cordic #(.IN_W(CW), .STAGES(CORDIC_STAGES), .TAG_W(1)) u_elbow (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(h_vld_reg),
        .in_y(CW'(signed'({1'b0, h_s_reg}))), .in_x(CW'(h_c_reg)), .in_tag(1'b0),
        .out_valid(ce_v), .out_angle(ang_elb), .out_tag()
    );
    tlik_cordic #(.IN_W(CW), .STAGES(CORDIC_STAGES), .TAG_W(1)) u_alpha (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(h_vld_reg),
        .in_y(CW'(h_h_reg)), .in_x(CW'(signed'({1'b0, h_r_reg}))), .in_tag(1'b0),
        .out_valid(ca_v), .out_angle(ang_alp), .out_tag()
    );
    tlik_cordic #(.IN_W(CW), .STAGES(CORDIC_STAGES), .TAG_W(1)) u_beta (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(h_vld_reg),
        .in_y(CW'(h_by_reg)), .in_x(h_bx_reg), .in_tag(1'b0),
        .out_valid(cbt_v), .out_angle(ang_bet), .out_tag()
    );

    // ---------------- final stage: round and saturate
    function automatic logic signed [20:0] to_frac(input logic signed [36:0] a);
        logic signed [36:0] t;
        t = a + 37'sd32768;
        return 21'(t >>> 16);
    endfunction

    logic signed [20:0] bf, ef, sf;
    logic signed [18:0] bo, eo;
    logic signed [19:0] so;
    always_comb
    begin
        bf = to_frac(37'(ang_base));
        ef = to_frac(37'(ang_elb) - 37'(PI_Q32));
        sf = to_frac(37'(ang_alp) - 37'(ang_bet));
        if (bf > 21'(PI_F))
            bo = 19'(PI_F);
        else if (bf < -21'(PI_F))
            bo = 19'(-PI_F);
        else
            bo = 19'(bf);
        if (ef > 21'sd0)
            eo = '0;
        else if (ef < -21'(PI_F))
            eo = 19'(-PI_F);
        else
            eo = 19'(ef);
        if (sf > 21'sd411774)
            so = 20'sd411774;
        else if (sf < -21'sd411774)
            so = -20'sd411774;
        else
            so = 20'(sf);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (adv)
            ov_reg <= cb_v && ce_v && ca_v && cbt_v;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            base_angle     <= bo;
            elbow_angle    <= eo;
            shoulder_angle <= so;
            reach_clamped  <= cb_tag[0];
        end
    end
endmodule

### bench/tlik_angle_checker.sv
// ----------------------------------------------------------------------------
// tlik_angle_checker
// watches the target and angle channels and the register port of the
// inverse kinematics core, predicts the angles of every accepted target
// beat and compares each whole angle set with the result beats in order
// ----------------------------------------------------------------------------
module tlik_angle_checker
    import tlik_pkg::*;
#(
    parameter int CORDIC_STAGES = 18
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [19:0] target_x,
    input  logic signed [19:0] target_y,
    input  logic signed [19:0] target_z,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [18:0] base_angle,
    input  logic signed [19:0] shoulder_angle,
    input  logic signed [18:0] elbow_angle,
    input  logic               reach_clamped,
    output int                 mismatch_count,
    output int                 angles_pending
);

    typedef struct packed {
        logic [18:0] base;
        logic [19:0] shoulder;
        logic [18:0] elbow;
        logic        clamped;
    } joint_angles_t;

    localparam int  FRAC   = 16;
    localparam longint ONE = 64'sd1 <<< FRAC;

    joint_angles_t angle_queue[$];
    longint        arm_reg [6];

    function automatic longint q32_to_frac(longint a);
        return (a + (64'sd1 <<< (31 - FRAC))) >>> (32 - FRAC);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // exact floor square root
    function automatic longint floor_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    // vectoring cordic, angle with 32 fraction bits
    function automatic longint cordic_atan2(longint y, longint x);
        longint zacc, t, m, ax, ay, dx, dy, step;
        int     n;
        zacc = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; zacc = longint'(HALF_PI_Q32);
            end
            else
            begin
                x = -y; y = t; zacc = -longint'(HALF_PI_Q32);
            end
        end
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        m  = ax > ay ? ax : ay;
        while (m >= (64'sd1 <<< 30))
        begin
            x = x >>> 1; y = y >>> 1; m = m >>> 1;
        end
        while (m < (64'sd1 <<< 29))
        begin
            x = x * 2; y = y * 2; m = m * 2;
        end
        n = CORDIC_STAGES > 32 ? 32 : CORDIC_STAGES;
        for (int i = 0; i < n; i++)
        begin
            dx   = y >>> i;
            dy   = x >>> i;
            step = longint'({32'd0, ATAN_Q32[i]});
            if (y >= 0)
            begin
                x = x + dx; y = y - dy; zacc = zacc + step;
            end
            else
            begin
                x = x - dx; y = y + dy; zacc = zacc - step;
            end
        end
        return zacc;
    endfunction

    // joint angles for one target point under the current link registers
    function automatic joint_angles_t solve_angles(longint x, longint y, longint z);
        joint_angles_t    a;
        longint           pi_f, l2, l3, r, h, reach, upper, d, num, den, c, s;
        longint           base, elbow, shoulder;
        longint unsigned  mag;
        logic             clamped;
        pi_f    = q32_to_frac(longint'(PI_Q32));
        l2      = arm_reg[REG_UPPER_ARM];
        l3      = arm_reg[REG_FOREARM];
        clamped = 1'b0;
        base    = clip(q32_to_frac(cordic_atan2(y, x)), -pi_f, pi_f);
        r       = floor_sqrt(x * x + y * y);
        h       = z - arm_reg[REG_SHOULDER_HEIGHT];
        reach   = floor_sqrt(r * r + h * h) - arm_reg[REG_WRIST_OFFSET];
        upper   = l2 + l3 - arm_reg[REG_REACH_MARGIN];
        d       = reach;
        // lower clamp wins over the upper one
        if (reach < arm_reg[REG_MIN_REACH])
        begin
            d = arm_reg[REG_MIN_REACH]; clamped = 1'b1;
        end
        else if (reach > upper)
        begin
            d = upper; clamped = 1'b1;
        end
        num = d * d - l2 * l2 - l3 * l3;
        den = 2 * l2 * l3;
        if (den == 0)
            c = num >= 0 ? ONE : -ONE;
        else if (num >= den)
            c = ONE;
        else if (num <= -den)
            c = -ONE;
        else
        begin
            mag = (longint'(num < 0 ? -num : num) << FRAC) / den;
            c   = num < 0 ? -longint'(mag) : longint'(mag);
        end
        s        = floor_sqrt(ONE * ONE - c * c);
        elbow    = clip(q32_to_frac(cordic_atan2(s, c) - longint'(PI_Q32)), -pi_f, 0);
        shoulder = q32_to_frac(cordic_atan2(h, r) - cordic_atan2(l3 * s, l2 * ONE - l3 * c));
        shoulder = clip(shoulder, -2 * pi_f, 2 * pi_f);
        a.base     = base[18:0];
        a.shoulder = shoulder[19:0];
        a.elbow    = elbow[18:0];
        a.clamped  = clamped;
        return a;
    endfunction

    assign angles_pending = angle_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        joint_angles_t exp_a;
        joint_angles_t got_a;
        int            idx;
        if (!rst_n)
        begin
            arm_reg[REG_SHOULDER_HEIGHT] = 21824;
            arm_reg[REG_UPPER_ARM]       = 20709;
            arm_reg[REG_FOREARM]         = 25166;
            arm_reg[REG_WRIST_OFFSET]    = 7012;
            arm_reg[REG_MIN_REACH]       = 6554;
            arm_reg[REG_REACH_MARGIN]    = 655;
            mismatch_count = 0;
        end
        else
        begin
            // register writes, out of range indexes ignored
            if (psel && penable && pwrite && pready)
            begin
                idx = paddr[4:2];
                if (idx == REG_MIN_REACH || idx == REG_REACH_MARGIN)
                    arm_reg[idx] = longint'(pwdata[15:0]);
                else if (idx <= REG_WRIST_OFFSET)
                    arm_reg[idx] = longint'(pwdata[17:0]);
            end
            // result beat against oldest prediction
            if (out_valid && !out_stall)
            begin
                got_a = '{base_angle, shoulder_angle, elbow_angle, reach_clamped};
                if (angle_queue.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result beat %p", got_a);
                end
                else
                begin
                    exp_a = angle_queue.pop_front();
                    if (got_a !== exp_a)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("angle mismatch: exp %p got %p", exp_a, got_a);
                    end
                end
            end
            // target beat
            if (in_valid && !in_stall)
                angle_queue.push_back(solve_angles(longint'(target_x),
                    longint'(target_y), longint'(target_z)));
        end
    end

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// drives target points and register settings into the inverse kinematics
// core under random idling and stalls; the checker beside it scores results
// ----------------------------------------------------------------------------
module tb
    import tlik_pkg::*;
();

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [19:0] target_x = '0;
    logic signed [19:0] target_y = '0;
    logic signed [19:0] target_z = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [18:0] base_angle;
    logic signed [19:0] shoulder_angle;
    logic signed [18:0] elbow_angle;
    logic               reach_clamped;

    int  mismatch_count;
    int  angles_pending;
    int  idle_cycles;
    bit  steady_flow;
    bit  hold_results;
    int  reach_span;

    localparam int WATCHDOG_LIMIT = 20000;

    two_link_arm_inverse_kinematics_core u_top (.*);

    tlik_angle_checker u_check (.*);

    always #2 clk = ~clk;

    // register write, setup then access, then back to idle
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_arm(input int sh, input int l2, input int l3,
                            input int wo, input int mn, input int mg);
        write_reg(REG_SHOULDER_HEIGHT, sh);
        write_reg(REG_UPPER_ARM, l2);
        write_reg(REG_FOREARM, l3);
        write_reg(REG_WRIST_OFFSET, wo);
        write_reg(REG_MIN_REACH, mn);
        write_reg(REG_REACH_MARGIN, mg);
        reach_span = l2 + l3 + wo + 8192;
        if (reach_span > 524287)
            reach_span = 524287;
    endtask

    // one target beat, at times with a random gap ahead of it unless steady_flow
    task automatic send_target(input logic [19:0] x, input logic [19:0] y,
                               input logic [19:0] z);
        if (!steady_flow && $urandom_range(99) < 17)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        target_x <= x;
        target_y <= y;
        target_z <= z;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_random_target();
        int span;
        span = reach_span;
        if ($urandom_range(99) < 70)
            send_target(20'($urandom_range(0, 2 * span) - span),
                        20'($urandom_range(0, 2 * span) - span),
                        20'($urandom_range(0, 2 * span) - span));
        else
            send_target(20'($urandom), 20'($urandom), 20'($urandom));
    endtask

    // wait until every predicted angle set has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (angles_pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // result side stalls
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_results)
            begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                hold_results = 1'b0;
            end
            out_stall <= steady_flow ? 1'b0 : ($urandom_range(99) < 17);
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        idle_cycles  = 0;
        steady_flow  = 1'b0;
        hold_results = 1'b0;
        reach_span   = 20709 + 25166 + 7012 + 8192;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corner targets on reset settings
        send_target(0, 0, 0);
        send_target(0, 0, 21824);
        send_target(20'sh7ffff, 20'sh7ffff, 20'sh7ffff);
        send_target(20'sh80000, 20'sh80000, 20'sh80000);
        send_target(20'sh80000, 0, 0);
        send_target(-20'sd30000, 20'sd1000, 20'sd30000);
        send_target(-20'sd30000, -20'sd1000, -20'sd30000);
        send_target(20'sd40000, 20'sd0, 20'sd21824);
        send_target(20'sd0, 20'sd200000, 20'sd21824);
        send_target(20'sd100, 20'sd100, 20'sd21900);
        send_target(20'sd30000, -20'sd20000, 20'sd40000);
        drain();

        // widest links and clamps
        load_arm(262143, 262143, 262143, 262143, 65535, 65535);
        send_target(20'sh7ffff, 20'sh7ffff, 20'sh80000);
        send_target(20'sh80000, 20'sh7ffff, 20'sh7ffff);
        send_target(0, 0, 0);
        send_target(20'sd1, -20'sd1, 20'sd1);
        drain();

        // zero links, all zero
        load_arm(0, 0, 0, 0, 0, 0);
        send_target(0, 0, 0);
        send_target(20'sd5000, 20'sd0, 20'sd0);
        send_target(-20'sd5, 20'sd7, -20'sd9);
        drain();

        // inverted limits, upper reach negative
        load_arm(21824, 1000, 2000, 0, 60000, 65535);
        send_target(20'sd70000, 20'sd0, 20'sd21824);
        send_target(20'sd100, 20'sd0, 20'sd21824);
        send_target(20'sh7ffff, 20'sh80000, 20'sh7ffff);
        drain();

        // random phases, each under fresh settings
        for (int phase = 0; phase < 9; phase++)
        begin
            if (phase == 0)
                load_arm(21824, 20709, 25166, 7012, 6554, 655);
            else if ($urandom_range(3) == 0)
                load_arm($urandom_range(0, 262143), $urandom_range(0, 262143),
                         $urandom_range(0, 262143), $urandom_range(0, 262143),
                         $urandom_range(0, 65535), $urandom_range(0, 65535));
            else
                load_arm($urandom_range(0, 65535), $urandom_range(0, 80000),
                         $urandom_range(0, 80000), $urandom_range(0, 16000),
                         $urandom_range(0, 20000), $urandom_range(0, 4000));
            // the hold phase sends more beats than the pipeline holds
            for (int n = 0; n < (phase == 1 ? 160 : 70); n++)
            begin
                // long result hold while targets keep coming
                if (phase == 1 && n == 5)
                begin
                    steady_flow  = 1'b1;
                    hold_results = 1'b1;
                end
                if (phase == 1 && n == 60)
                    steady_flow = 1'b0;
                // stretch with no idling on either side
                if (phase == 4)
                    steady_flow = (n < 50);
                send_random_target();
            end
            steady_flow = 1'b0;
            drain();
        end

        if (mismatch_count == 0 && angles_pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
